// ===== hw/rtl/lppp_pkg.sv =====
package lppp_pkg;

  localparam int IMAGE_WIDTH  = 2048;
  localparam int IMAGE_HEIGHT = 1536;
  localparam int PIX_W = 11;
  localparam int QW = 13;

  localparam logic [2:0] REG_ROW0_01 = 3'd0;
  localparam logic [2:0] REG_ROW0_23 = 3'd1;
  localparam logic [2:0] REG_ROW1_01 = 3'd2;
  localparam logic [2:0] REG_ROW1_23 = 3'd3;
  localparam logic [2:0] REG_ROW2_01 = 3'd4;
  localparam logic [2:0] REG_ROW2_23 = 3'd5;
  localparam logic [2:0] REG_THRESH  = 3'd6;

  localparam logic [1:0] ST_HIT    = 2'd0;
  localparam logic [1:0] ST_LOW    = 2'd1;
  localparam logic [1:0] ST_REGION = 2'd2;
  localparam logic [1:0] ST_OFF    = 2'd3;

  localparam logic signed [16:0] X_MIN = 17'sd0;
  localparam logic signed [16:0] X_MAX = 17'sd50000;
  localparam logic signed [16:0] Y_MIN = -17'sd30000;
  localparam logic signed [16:0] Y_MAX = 17'sd30000;
  localparam logic signed [16:0] Z_MIN = -17'sd2000;
  localparam logic signed [16:0] Z_MAX = 17'sd1000;
  localparam logic signed [16:0] W_ONE = 17'sd1000;

endpackage

// ===== hw/rtl/lidar_point_to_pixel_projection.sv =====
// Channel   | Ports                                   | Direction
// config    | cfg_we, cfg_index[2:0], cfg_data[63:0]  | in
// request   | start, x_mm, y_mm, z_mm, intensity      | in (busy: out)
// result    | done, status, pixel_u, pixel_v          | out
//
// One request per cycle. A request passes through 19 register stages: four front
// stages (screening, multiply, sum, sign handling), the divider input register, the
// 13 bit-per-stage divider stages and the output stage.
// busy is always low: nothing stalls, and the receiver cannot stall either.
// Reset is synchronous; it clears the valid pipeline and the coefficients, sets thresh to 230.
module lidar_point_to_pixel_projection (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic signed [16:0] x_mm,
  input  logic signed [16:0] y_mm,
  input  logic signed [16:0] z_mm,
  input  logic [7:0]         intensity,
  output logic               done,
  output logic [1:0]         status,
  output logic [lppp_pkg::PIX_W-1:0] pixel_u,
  output logic [lppp_pkg::PIX_W-1:0] pixel_v
);
  import lppp_pkg::*;

  // Coefficient registers; the user writes them only while idle, the block does not enforce it.
  logic [63:0] coef [6];
  logic [7:0]  thresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) coef[i] <= '0;
      thresh <= 8'd230;
    end else if (cfg_we) begin
      if (cfg_index == REG_THRESH) thresh <= cfg_data[7:0];
      else if (cfg_index <= REG_ROW2_23) coef[cfg_index] <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // Stage 1: register the point and screen it against intensity and region.
  logic               s1_v;
  logic signed [16:0] s1_p [4];
  logic [1:0]         s1_st;
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else s1_v <= start;
    s1_p[0] <= x_mm;
    s1_p[1] <= y_mm;
    s1_p[2] <= z_mm;
    s1_p[3] <= W_ONE;
    if (intensity < thresh) s1_st <= ST_LOW;
    else if (z_mm < Z_MIN || z_mm > Z_MAX || x_mm < X_MIN || x_mm > X_MAX ||
             y_mm < Y_MIN || y_mm > Y_MAX) s1_st <= ST_REGION;
    else s1_st <= ST_HIT;
  end

  // Stage 2: twelve 32x17 products, one per coefficient.
  logic              s2_v;
  logic [1:0]        s2_st;
  logic signed [48:0] s2_prod [3][4];
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else s2_v <= s1_v;
    s2_st <= s1_st;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        s2_prod[r][c] <= $signed(coef[2*r + c/2][32*(c%2) +: 32]) * s1_p[c];
      end
    end
  end

  // Stage 3: sum of four per row.
  logic              s3_v;
  logic [1:0]        s3_st;
  logic signed [50:0] s3_sum [3];
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else s3_v <= s2_v;
    s3_st <= s2_st;
    for (int r = 0; r < 3; r++) begin
      s3_sum[r] <= 51'(s2_prod[r][0]) + 51'(s2_prod[r][1]) +
                   51'(s2_prod[r][2]) + 51'(s2_prod[r][3]);
    end
  end

  // Stage 4: magnitudes and sign screening.  A quotient is negative when a
  // nonzero numerator has a sign opposite to the depth.
  logic        s4_v;
  logic [1:0]  s4_st;
  logic [51:0] s4_nu, s4_nv, s4_den;
  logic        s4_ok;
  logic        dneg, uneg, vneg;
  assign dneg = s3_sum[2][50];
  assign uneg = s3_sum[0][50];
  assign vneg = s3_sum[1][50];
  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else s4_v <= s3_v;
    s4_st  <= s3_st;
    s4_nu  <= uneg ? 52'(-s3_sum[0]) : 52'(s3_sum[0]);
    s4_nv  <= vneg ? 52'(-s3_sum[1]) : 52'(s3_sum[1]);
    s4_den <= dneg ? 52'(-s3_sum[2]) : 52'(s3_sum[2]);
    s4_ok  <= (s3_sum[2] != '0) &&
              !(s3_sum[0] != '0 && uneg != dneg) &&
              !(s3_sum[1] != '0 && vneg != dneg);
  end

  logic            du_v, dv_v, du_ok, dv_ok;
  logic [QW-1:0]   du_q, dv_q;
  logic [1:0]      du_st, dv_st;

  lppp_div u_div_u (
    .clk, .rst, .in_valid(s4_v), .in_num(s4_nu), .in_den(s4_den),
    .in_ok(s4_ok), .in_status(s4_st),
    .out_valid(du_v), .out_quo(du_q), .out_ok(du_ok), .out_status(du_st)
  );
  lppp_div u_div_v (
    .clk, .rst, .in_valid(s4_v), .in_num(s4_nv), .in_den(s4_den),
    .in_ok(s4_ok), .in_status(s4_st),
    .out_valid(dv_v), .out_quo(dv_q), .out_ok(dv_ok), .out_status(dv_st)
  );

  // Output stage: image bounds and final status.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= du_v;
    if (du_st != ST_HIT) begin
      status <= du_st; pixel_u <= '0; pixel_v <= '0;
    end else if (!du_ok || !dv_ok || du_q >= QW'(IMAGE_WIDTH) ||
                 dv_q >= QW'(IMAGE_HEIGHT)) begin
      status <= ST_OFF; pixel_u <= '0; pixel_v <= '0;
    end else begin
      status <= ST_HIT; pixel_u <= du_q[PIX_W-1:0]; pixel_v <= dv_q[PIX_W-1:0];
    end
  end

  a_lanes: assert property (@(posedge clk) disable iff (rst) du_v == dv_v)
    else $error("divider lanes out of step");
  a_stat: assert property (@(posedge clk) disable iff (rst) du_v |-> du_st == dv_st)
    else $error("status mismatch between lanes");
  a_miss: assert property (@(posedge clk) disable iff (rst)
      done && status != ST_HIT |-> pixel_u == '0 && pixel_v == '0)
    else $error("pixel set on a miss");
endmodule

// ===== hw/rtl/lppp_div.sv =====
module lppp_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [51:0]         in_num,
  input  logic [51:0]         in_den,
  input  logic                in_ok,
  input  logic [1:0]          in_status,
  output logic                out_valid,
  output logic [lppp_pkg::QW-1:0] out_quo,
  output logic                out_ok,
  output logic [1:0]          out_status
);
  import lppp_pkg::*;

  // Restoring divider, one quotient bit per stage.  The quotient is not
  // clamped: a result of 2^QW or more clears the ok flag.
  logic [51:0]  rem_q  [QW+1];
  logic [51:0]  den_q  [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic         ok_q   [QW+1];
  logic         vld_q  [QW+1];
  logic [1:0]   st_q   [QW+1];

  logic [64:0] over_cmp;
  assign over_cmp = {in_den, {QW{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) vld_q[0] <= 1'b0;
    else vld_q[0] <= in_valid;
    rem_q[0] <= in_num;
    den_q[0] <= in_den;
    quo_q[0] <= '0;
    ok_q[0]  <= in_ok && ({13'd0, in_num} < over_cmp);
    st_q[0]  <= in_status;
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    localparam int SH = QW - 1 - i;
    logic [64:0] trial;
    logic        take;
    assign trial = {13'd0, den_q[i]} << SH;
    assign take  = {13'd0, rem_q[i]} >= trial;
    always_ff @(posedge clk) begin
      if (rst) vld_q[i+1] <= 1'b0;
      else vld_q[i+1] <= vld_q[i];
      rem_q[i+1] <= take ? rem_q[i] - trial[51:0] : rem_q[i];
      den_q[i+1] <= den_q[i];
      quo_q[i+1] <= quo_q[i] | (take ? (QW'(1) << SH) : '0);
      ok_q[i+1]  <= ok_q[i];
      st_q[i+1]  <= st_q[i];
    end
  end

  assign out_valid  = vld_q[QW];
  assign out_quo    = quo_q[QW];
  assign out_ok     = ok_q[QW];
  assign out_status = st_q[QW];
endmodule

// ===== test/testbench.sv =====
module testbench;
  import lppp_pkg::*;

  // Clock, reset and the block's ports. Every input is given a known value at time zero.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [16:0] x_mm = '0;
  logic signed [16:0] y_mm = '0;
  logic signed [16:0] z_mm = '0;
  logic [7:0]         intensity = '0;
  logic               done;
  logic [1:0]         status;
  logic [10:0]        pixel_u;
  logic [10:0]        pixel_v;

  // The drain margin and the watchdog limit are set well above the block's result latency.
  // The watchdog limit also covers the longest gap between requests.
  localparam int LATENCY = 19;
  localparam int DRAIN_CYCLES = 4 * LATENCY;
  localparam int WATCHDOG_LIMIT = 2000;

  // One expected projection result.
  typedef struct packed {
    logic [1:0]  st;
    logic [10:0] u;
    logic [10:0] v;
  } pixel_result_t;

  // This is the testbench's own copy of the configuration registers.
  logic [63:0]   coef_mirror [6];
  logic [7:0]    thresh_mirror;
  pixel_result_t pending_pixels [$];
  int            errors = 0;
  int            idle_cycles = 0;

  lidar_point_to_pixel_projection u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy), .x_mm(x_mm), .y_mm(y_mm), .z_mm(z_mm),
    .intensity(intensity), .done(done), .status(status), .pixel_u(pixel_u),
    .pixel_v(pixel_v)
  );

  always #2 clk = ~clk;

  // The dot product of one matrix row with [x, y, z, 1000]. Each coefficient is a signed
  // 32-bit half of a packed register. The result is exact in 64 bits.
  function automatic longint row_sum(int row, longint px, longint py, longint pz);
    logic [63:0] lo;
    logic [63:0] hi;
    lo = coef_mirror[2 * row];
    hi = coef_mirror[2 * row + 1];
    return longint'($signed(lo[31:0])) * px + longint'($signed(lo[63:32])) * py
         + longint'($signed(hi[31:0])) * pz + longint'($signed(hi[63:32])) * 1000;
  endfunction

  // The truncated quotient. The function returns 0 when the pixel is off the image:
  // a negative quotient, or one that is not below the limit.
  function automatic bit pixel_coord(longint num, longint den, longint limit,
                                     output logic [10:0] pix);
    longint an;
    longint ad;
    longint q;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    pix = '0;
    if (an != 0 && ((num < 0) != (den < 0))) return 1'b0;
    q = an / ad;
    if (q >= limit) return 1'b0;
    pix = q[10:0];
    return 1'b1;
  endfunction

  // The expected result for one point. The intensity test comes first, then the region
  // test, then the projection.
  function automatic pixel_result_t project_point(logic signed [16:0] px,
      logic signed [16:0] py, logic signed [16:0] pz, logic [7:0] inten);
    pixel_result_t r;
    longint nu;
    longint nv;
    longint dz;
    logic [10:0] pu;
    logic [10:0] pv;
    r = '{st: ST_HIT, u: '0, v: '0};
    if (inten < thresh_mirror) begin
      r.st = ST_LOW;
    end else if (pz < Z_MIN || pz > Z_MAX || px < X_MIN || px > X_MAX ||
                 py < Y_MIN || py > Y_MAX) begin
      r.st = ST_REGION;
    end else begin
      nu = row_sum(0, px, py, pz);
      nv = row_sum(1, px, py, pz);
      dz = row_sum(2, px, py, pz);
      if (dz == 0 || !pixel_coord(nu, dz, IMAGE_WIDTH, pu) ||
          !pixel_coord(nv, dz, IMAGE_HEIGHT, pv)) begin
        r.st = ST_OFF;
      end else begin
        r.u = pu;
        r.v = pv;
      end
    end
    return r;
  endfunction

  // A register write is made only while the block is idle. The testbench mirror is
  // updated at the same time.
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_THRESH) begin
      thresh_mirror = val[7:0];
    end else begin
      coef_mirror[idx] = val;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // This task sends one request after a random gap. The request stays high across
  // back-to-back items, and it is lowered only when a gap follows.
  task automatic send_point(logic signed [16:0] px, logic signed [16:0] py,
                            logic signed [16:0] pz, logic [7:0] inten, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    x_mm <= px;
    y_mm <= py;
    z_mm <= pz;
    intensity <= inten;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_pixels.insert(pending_pixels.size(), project_point(px, py, pz, inten));
    @(negedge clk);
  endtask

  // This task waits until every expected result has arrived. It then lets the pipeline settle.
  task automatic drain;
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // This loads a physically plausible camera: u = fu * y / x + cu and
  // v = fv * z / x + cv, with the depth taken as x. Each coefficient is in Q13.19.
  task automatic load_camera(int fu, int cu, int fv, int cv);
    write_reg(REG_ROW0_01, {32'(fu << 19), 32'(cu << 19)});
    write_reg(REG_ROW0_23, 64'd0);
    write_reg(REG_ROW1_01, {32'd0, 32'(cv << 19)});
    write_reg(REG_ROW1_23, {32'd0, 32'(fv << 19)});
    write_reg(REG_ROW2_01, {32'd0, 32'(1 << 19)});
    write_reg(REG_ROW2_23, 64'd0);
  endtask

  // This task draws a point. Most draws fall inside the region of interest, and the rest
  // may take any 17-bit value.
  task automatic random_point(output logic signed [16:0] px, output logic signed [16:0] py,
                              output logic signed [16:0] pz, output logic [7:0] inten);
    if ($urandom_range(0, 3) != 0) begin
      px = 17'($urandom_range(0, 50000));
      py = 17'($signed($urandom_range(0, 60000)) - 30000);
      pz = 17'($signed($urandom_range(0, 3000)) - 2000);
    end else begin
      px = 17'($urandom);
      py = 17'($urandom);
      pz = 17'($urandom);
    end
    inten = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(thresh_mirror, 255)) : 8'($urandom);
  endtask

  // The directed test covers the intensity and region edges, zero depth, a negative
  // depth and a negative quotient, the image edges, and every result status.
  task automatic test_directed;
    send_point(17'sd1000, 17'sd0, 17'sd0, 8'd255);     // zero matrix, zero depth
    drain();
    write_reg(REG_THRESH, 8'd0);
    load_camera(1806, 1033, 1805, 816);
    send_point(17'sd10000, 17'sd0, 17'sd0, 8'd0, 1);
    send_point(17'sd0, 17'sd0, 17'sd0, 8'd0, 1);       // x of zero gives zero depth
    send_point(17'sd50000, 17'sd30000, 17'sd1000, 8'd1, 1);
    send_point(17'sd50001, 17'sd0, 17'sd0, 8'd9);
    send_point(-17'sd1, 17'sd0, 17'sd0, 8'd9);
    send_point(17'sd1000, -17'sd30000, -17'sd2000, 8'd9);
    send_point(17'sd1000, -17'sd30001, 17'sd0, 8'd9);
    send_point(17'sd1000, 17'sd30001, 17'sd0, 8'd9);
    send_point(17'sd1000, 17'sd0, -17'sd2001, 8'd9);
    send_point(17'sd1000, 17'sd0, 17'sd1001, 8'd9);
    send_point(-17'sd65536, -17'sd65536, -17'sd65536, 8'd255);
    send_point(17'sd65535, 17'sd65535, 17'sd65535, 8'd255);
    send_point(17'sd1, 17'sd0, 17'sd0, 8'd128);        // u lands on the principal point
    send_point(17'sd1000, -17'sd600, 17'sd0, 8'd128);  // negative u
    send_point(17'sd30000, -17'sd17000, 17'sd0, 8'd128); // u lands near the left edge
    drain();
    write_reg(REG_THRESH, 8'd255);
    send_point(17'sd1000, 17'sd0, 17'sd0, 8'd254);
    send_point(17'sd1000, 17'sd0, 17'sd0, 8'd255);
    drain();
    // With a negative depth row, a non-negative quotient can still come out.
    write_reg(REG_ROW2_01, {32'd0, 32'hFFF8_0000});
    write_reg(REG_ROW0_01, {32'd0, 32'hFFF8_0000});
    write_reg(REG_ROW1_01, {32'd0, 32'hFFF8_0000});
    send_point(17'sd1000, 17'sd0, 17'sd0, 8'd255);
    send_point(17'sd1000, 17'sd5, 17'sd0, 8'd255);
    drain();
  endtask

  // This task writes every register with random coefficients in Q13.19, and it sets a
  // random threshold.
  task automatic test_random_matrix(int count);
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic signed [16:0] pz;
    logic [7:0] inten;
    for (int i = 0; i < 6; i++) write_reg(3'(i), {$urandom, $urandom});
    write_reg(REG_THRESH, 8'($urandom));
    for (int i = 0; i < count; i++) begin
      random_point(px, py, pz, inten);
      send_point(px, py, pz, inten);
    end
    drain();
  endtask

  // The camera test varies the principal point and the focal length, so that many
  // points land on the image.
  task automatic test_camera(int count, logic [7:0] thr);
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic signed [16:0] pz;
    logic [7:0] inten;
    load_camera($urandom_range(200, 3000), $urandom_range(0, 2047),
                $urandom_range(200, 3000), $urandom_range(0, 1535));
    write_reg(REG_THRESH, thr);
    for (int i = 0; i < count; i++) begin
      random_point(px, py, pz, inten);
      send_point(px, py, pz, inten);
    end
    drain();
  endtask

  // This process checks each result strobe against the oldest expected result.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: status %0d u %0d v %0d", status, pixel_u, pixel_v);
        errors++;
      end else begin
        pixel_result_t exp_r;
        exp_r = pending_pixels.pop_front();
        if (status !== exp_r.st) begin
          $error("status expected %0d actual %0d", exp_r.st, status);
          errors++;
        end
        if (pixel_u !== exp_r.u) begin
          $error("pixel_u expected %0d actual %0d", exp_r.u, pixel_u);
          errors++;
        end
        if (pixel_v !== exp_r.v) begin
          $error("pixel_v expected %0d actual %0d", exp_r.v, pixel_v);
          errors++;
        end
      end
    end
  end

  // The watchdog counts cycles with no accepted request, no result and no register write.
  always @(posedge clk) begin
    if ((start && !busy) || done || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 6; i++) coef_mirror[i] = '0;
    thresh_mirror = 8'd230;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_camera(100, 8'd0);
    test_camera(100, 8'd40);
    test_random_matrix(60);
    test_camera(80, 8'd230);
    test_random_matrix(40);
    if (pending_pixels.size() != 0) begin
      $error("%0d results never arrived", pending_pixels.size());
      errors++;
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
